>>> hdl/ic64_pkg.sv
// ----------------------------------------------------------------------------
// ic64_pkg
// Types and register-map constants shared by the 64-source interrupt controller.
// ----------------------------------------------------------------------------
package ic64_pkg;

	// function codes
	localparam logic [1:0] FN_READ     = 2'd0;
	localparam logic [1:0] FN_WRITE    = 2'd1;
	localparam logic [1:0] FN_ASSERT   = 2'd2;
	localparam logic [1:0] FN_DEASSERT = 2'd3;

	typedef logic [7:0] widx_t;

	// word indexes of the register map (_L = bits 31..0, _H = bits 63..32)
	localparam widx_t W_ENABLE_L = 8'd0;
	localparam widx_t W_ENABLE_H = 8'd1;
	localparam widx_t W_MASK_L   = 8'd2;
	localparam widx_t W_MASK_H   = 8'd3;
	localparam widx_t W_FORCE_L  = 8'd4;
	localparam widx_t W_FORCE_H  = 8'd5;
	localparam widx_t W_RAW_L    = 8'd6;
	localparam widx_t W_RAW_H    = 8'd7;
	localparam widx_t W_STAT_L   = 8'd8;
	localparam widx_t W_STAT_H   = 8'd9;
	localparam widx_t W_FINAL_L  = 8'd12;
	localparam widx_t W_FINAL_H  = 8'd13;

	// access sizes in bytes
	localparam logic [2:0] SZ_BYTE = 3'd1;
	localparam logic [2:0] SZ_HALF = 3'd2;
	localparam logic [2:0] SZ_WORD = 3'd4;

	typedef struct packed {
		logic [1:0]  func;
		logic [9:0]  byte_address;
		logic [2:0]  access_size;
		logic [31:0] write_data;
		logic [6:0]  source_id;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        size_error;
		logic        irq_pending;
	} rsp_t;

endpackage

>>> hdl/ic64_chan_if.sv
// ----------------------------------------------------------------------------
// ic64_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface ic64_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t word;

	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
endinterface

>>> hdl/ic64_ram.sv
// ----------------------------------------------------------------------------
// ic64_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ic64_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH)-1:0]        waddr,
	input  logic [WIDTH-1:0]                wdata,
	input  logic                            re,
	input  logic [$clog2(DEPTH)-1:0]        raddr,
	output logic [WIDTH-1:0]                rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> hdl/interrupt_controller_64_source_top.sv
// ----------------------------------------------------------------------------
// interrupt_controller_64_source_top
// A word is answered through the RAM read and stage 1, then the result register.
// Throughput: one word per cycle once running, unless rsp.ready stalls; the plain-word
//   RAM is read at accept and written back as the word leaves stage 1; same-word overlap is forwarded.
// Reset: control vectors clear at once; a clearing pass then zeroes every RAM
//   entry, with req.ready low, before the first word is taken.
// ----------------------------------------------------------------------------
module interrupt_controller_64_source_top #(
	parameter int WINDOW_WORDS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	ic64_chan_if.sink    req,
	ic64_chan_if.source  rsp
);
	localparam int AW = $clog2(WINDOW_WORDS);

	// sequencer states
	localparam logic ST_CLEAR = 1'b0;
	localparam logic ST_RUN   = 1'b1;

	logic           st_q;
	logic [AW-1:0]  clr_cnt_q;

	// stage 1: item whose RAM read is in flight
	logic           valid_s1;
	ic64_pkg::req_t req_s1;
	logic           fwd_hit_s1;
	logic [31:0]    fwd_data_s1;

	// interrupt vectors
	logic [63:0] en_q, msk_q, frc_q, raw_q;
	logic [63:0] en_d, msk_d, frc_d, raw_d;

	// result register
	logic           rsp_valid_q;
	ic64_pkg::rsp_t rsp_q;

	// RAM ports
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [31:0]    ram_wdata;
	logic [31:0]    ram_rdata;

	logic           s1_done;
	logic           acc;
	ic64_pkg::widx_t idx;
	logic [4:0]     shamt;
	logic           in_range;
	logic           ctrl_word;
	logic           size_ok;
	logic [31:0]    smask;
	logic [31:0]    lane_mask;
	logic [31:0]    word_mem;
	logic [31:0]    word_val;
	logic [31:0]    wword;
	logic [31:0]    rd_val;
	logic [63:0]    status;
	logic [63:0]    fin;
	logic [63:0]    fin_d;
	logic           is_rd, is_wr, wr_ok, mem_we_run;

	// ---------------- handshake ----------------
	assign s1_done   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = (st_q == ST_RUN) && (!valid_s1 || s1_done);
	assign acc       = req.valid && req.ready;

	// ---------------- stage 1 decode ----------------
	assign idx      = req_s1.byte_address[9:2];
	assign shamt    = {req_s1.byte_address[1:0], 3'b000};
	assign in_range = 32'(idx) < 32'(WINDOW_WORDS);
	assign size_ok  = (req_s1.access_size == ic64_pkg::SZ_BYTE) ||
	                  (req_s1.access_size == ic64_pkg::SZ_HALF) ||
	                  (req_s1.access_size == ic64_pkg::SZ_WORD);
	assign is_rd    = req_s1.func == ic64_pkg::FN_READ;
	assign is_wr    = req_s1.func == ic64_pkg::FN_WRITE;
	assign wr_ok    = is_wr && size_ok;

	always_comb begin
		case (req_s1.access_size)
			ic64_pkg::SZ_BYTE: smask = 32'h0000_00ff;
			ic64_pkg::SZ_HALF: smask = 32'h0000_ffff;
			default:           smask = 32'hffff_ffff;
		endcase
	end

	// lanes past the word end fall off the top
	assign lane_mask = smask << shamt;

	// RAM data, or the word written back to the same entry at accept
	assign word_mem = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;

	assign status = (raw_q | frc_q) & en_q;
	assign fin    = status & ~msk_q;

	// current value of the addressed word
	always_comb begin
		ctrl_word = 1'b1;
		case (idx)
			ic64_pkg::W_ENABLE_L: word_val = en_q[31:0];
			ic64_pkg::W_ENABLE_H: word_val = en_q[63:32];
			ic64_pkg::W_MASK_L:   word_val = msk_q[31:0];
			ic64_pkg::W_MASK_H:   word_val = msk_q[63:32];
			ic64_pkg::W_FORCE_L:  word_val = frc_q[31:0];
			ic64_pkg::W_FORCE_H:  word_val = frc_q[63:32];
			ic64_pkg::W_RAW_L:    word_val = raw_q[31:0];
			ic64_pkg::W_RAW_H:    word_val = raw_q[63:32];
			ic64_pkg::W_STAT_L:   word_val = status[31:0];
			ic64_pkg::W_STAT_H:   word_val = status[63:32];
			ic64_pkg::W_FINAL_L:  word_val = fin[31:0];
			ic64_pkg::W_FINAL_H:  word_val = fin[63:32];
			default: begin
				ctrl_word = 1'b0;
				word_val  = in_range ? word_mem : 32'd0;
			end
		endcase
	end

	assign rd_val = (word_val >> shamt) & smask;
	assign wword  = (word_val & ~lane_mask) | ((req_s1.write_data << shamt) & lane_mask);

	// plain-storage write back
	assign mem_we_run = s1_done && wr_ok && !ctrl_word && in_range;

	// next interrupt vectors
	always_comb begin
		en_d  = en_q;
		msk_d = msk_q;
		frc_d = frc_q;
		raw_d = raw_q;
		if (s1_done) begin
			if (wr_ok) begin
				case (idx)
					ic64_pkg::W_ENABLE_L: en_d[31:0]   = wword;
					ic64_pkg::W_ENABLE_H: en_d[63:32]  = wword;
					ic64_pkg::W_MASK_L:   msk_d[31:0]  = wword;
					ic64_pkg::W_MASK_H:   msk_d[63:32] = wword;
					ic64_pkg::W_FORCE_L:  frc_d[31:0]  = wword;
					ic64_pkg::W_FORCE_H:  frc_d[63:32] = wword;
					default: ;
				endcase
			end
			// sources 64 and up are ignored
			if (!req_s1.source_id[6]) begin
				if (req_s1.func == ic64_pkg::FN_ASSERT) begin
					raw_d[req_s1.source_id[5:0]] = 1'b1;
				end else if (req_s1.func == ic64_pkg::FN_DEASSERT) begin
					raw_d[req_s1.source_id[5:0]] = 1'b0;
				end
			end
		end
	end

	assign fin_d = (raw_d | frc_d) & en_d & ~msk_d;

	// ---------------- RAM ----------------
	always_comb begin
		if (st_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = 32'd0;
		end else begin
			ram_we    = mem_we_run;
			ram_waddr = AW'(idx);
			ram_wdata = wword;
		end
	end

	ic64_ram #(
		.WIDTH (32),
		.DEPTH (WINDOW_WORDS)
	) u_words (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (acc),
		.raddr (AW'(req.word.byte_address[9:2])),
		.rdata (ram_rdata)
	);

	// ---------------- sequencer and clearing pass ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else if (st_q == ST_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(WINDOW_WORDS - 1)) begin
				st_q <= ST_RUN;
			end
		end
	end

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_hit_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
			en_q        <= '0;
			msk_q       <= '0;
			frc_q       <= '0;
			raw_q       <= '0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			// next item reads the entry being written now: RAM gives old data;
			// the hit is held for as long as that item waits in stage 1
			if (acc) begin
				fwd_hit_s1 <= mem_we_run && (req.word.byte_address[9:2] == idx);
			end
			if (s1_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			en_q  <= en_d;
			msk_q <= msk_d;
			frc_q <= frc_d;
			raw_q <= raw_d;
		end
	end

	// ---------------- payload ----------------
	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1      <= req.word;
			fwd_data_s1 <= wword;
		end
		if (s1_done) begin
			rsp_q.read_data   <= (is_rd && size_ok) ? rd_val : 32'd0;
			rsp_q.size_error  <= (is_rd || is_wr) && !size_ok;
			rsp_q.irq_pending <= |fin_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.word  = rsp_q;
endmodule
